[hw/rtl/pfa_pkg.sv]
// Shared constants, command/status types and helpers for the pairwise fork arbiter.
package pfa_pkg;

    localparam int MAX_SEATS = 8;
    localparam int SEAT_W    = $clog2(MAX_SEATS);
    localparam int COUNT_W   = $clog2(MAX_SEATS + 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(5);

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic take_item;   // an input transfer happens this cycle
        logic scan_step;   // evaluate one seat of the release scan
        logic emit_load;   // move the lowest pending grant into the output register
    } pfa_cmd_t;

    typedef struct packed {
        logic seat_ok;      // incoming seat is below the effective count
        logic is_release;   // incoming item is a release
        logic both_free;    // both resources of the incoming seat are free
        logic scan_last;    // scan pointer sits on the highest active seat
        logic grant_now;    // seat under the scan pointer is granted this cycle
        logic mask_any;     // at least one grant is pending
        logic mask_single;  // exactly one grant is pending
        logic out_free;     // output register can take a new grant
    } pfa_status_t;

    // Right-hand neighbor of seat s in a ring of n seats.
    function automatic logic [SEAT_W-1:0] right_of(input logic [SEAT_W-1:0] s,
                                                   input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] nxt;
        nxt = COUNT_W'(s) + COUNT_W'(1);
        return (nxt >= n) ? '0 : nxt[SEAT_W-1:0];
    endfunction

endpackage

[hw/rtl/pfa_datapath.sv]
// Datapath: resource and waiting stores, grant mask, scan pointer and output register.
module pfa_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfa_pkg::COUNT_W-1:0]   cfg_wdata,
    input  logic                          item_action,
    input  logic [pfa_pkg::SEAT_W-1:0]    item_seat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [pfa_pkg::SEAT_W-1:0]    out_seat,
    output logic                          out_last,
    input  pfa_pkg::pfa_cmd_t             cmd,
    output pfa_pkg::pfa_status_t          status
);

    localparam int N = pfa_pkg::MAX_SEATS;
    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    logic [pfa_pkg::COUNT_W-1:0] count_reg;
    logic [N-1:0]                free_reg, free_next;
    logic [N-1:0]                wait_reg, wait_next;
    logic [N-1:0]                mask_reg, mask_next;
    logic [pfa_pkg::SEAT_W-1:0]  scan_reg, scan_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pfa_pkg::SEAT_W-1:0]  out_seat_reg, out_seat_next;
    logic                        out_last_reg, out_last_next;

    logic [pfa_pkg::COUNT_W-1:0] n_eff;
    logic [pfa_pkg::SEAT_W-1:0]  item_right;
    logic [pfa_pkg::SEAT_W-1:0]  scan_right;
    logic [N-1:0]                item_bits;
    logic [N-1:0]                scan_bits;
    logic [N-1:0]                mask_rest;
    logic [pfa_pkg::SEAT_W-1:0]  low_idx;

    always_comb
    begin
        if (count_reg == '0)
            n_eff = pfa_pkg::COUNT_W'(1);
        else if (count_reg > pfa_pkg::COUNT_W'(N))
            n_eff = pfa_pkg::COUNT_W'(N);
        else
            n_eff = count_reg;
    end

    assign item_right = pfa_pkg::right_of(item_seat, n_eff);
    assign scan_right = pfa_pkg::right_of(scan_reg, n_eff);
    assign item_bits  = (ONE << item_seat) | (ONE << item_right);
    assign scan_bits  = (ONE << scan_reg) | (ONE << scan_right);
    assign mask_rest  = mask_reg & (mask_reg - ONE);

    // Lowest pending grant
    always_comb
    begin
        low_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                low_idx = pfa_pkg::SEAT_W'(i);
        end
    end

    always_comb
    begin
        status.seat_ok     = pfa_pkg::COUNT_W'(item_seat) < n_eff;
        status.is_release  = item_action == pfa_pkg::ACT_RELEASE;
        status.both_free   = free_reg[item_seat] && free_reg[item_right];
        status.scan_last   = pfa_pkg::COUNT_W'(scan_reg) == (n_eff - pfa_pkg::COUNT_W'(1));
        status.grant_now   = wait_reg[scan_reg] && free_reg[scan_reg] && free_reg[scan_right];
        status.mask_any    = mask_reg != '0;
        status.mask_single = (mask_reg != '0) && (mask_rest == '0);
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        free_next      = free_reg;
        wait_next      = wait_reg;
        mask_next      = mask_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        out_seat_next  = out_seat_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cmd.take_item && status.seat_ok)
        begin
            if (status.is_release)
            begin
                free_next = free_reg | item_bits;
                scan_next = '0;
                mask_next = '0;
            end
            else if (status.both_free)
            begin
                free_next = free_reg & ~item_bits;
                mask_next = ONE << item_seat;
            end
            else
            begin
                wait_next = wait_reg | (ONE << item_seat);
            end
        end

        if (cmd.scan_step)
        begin
            if (status.grant_now)
            begin
                free_next = free_reg & ~scan_bits;
                wait_next = wait_reg & ~(ONE << scan_reg);
                mask_next = mask_reg | (ONE << scan_reg);
            end
            scan_next = scan_reg + pfa_pkg::SEAT_W'(1);
        end

        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            out_seat_next  = low_idx;
            out_last_next  = status.mask_single;
            mask_next      = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= pfa_pkg::COUNT_RESET;
            free_reg      <= '1;
            wait_reg      <= '0;
            mask_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;
            free_reg      <= free_next;
            wait_reg      <= wait_next;
            mask_reg      <= mask_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_seat_reg <= out_seat_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_seat  = out_seat_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/pfa_ctrl.sv]
// Controller: sequences intake, release scan and grant emission.
module pfa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfa_pkg::pfa_status_t status,
    output pfa_pkg::pfa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.take_item = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.emit_load = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item = in_valid;
                if (in_valid && status.seat_ok)
                begin
                    if (status.is_release)
                        state_next = ST_SCAN;
                    else if (status.both_free)
                        state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = (status.mask_any || status.grant_now) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit_load = status.out_free && status.mask_any;
                if (!status.mask_any || (status.out_free && status.mask_single))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

[hw/rtl/pairwise_fork_arbiter_core.sv]
// Top level of the pairwise fork arbiter: ring of seats sharing neighbor resources.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser[0] action, s_tdata[2:0] seat
// m_*       out  m_tvalid/m_tready  m_tdata[2:0] granted_seat, m_tlast last_grant
// cfg_*     in   cfg_we             cfg_wdata[3:0] seat_count
//
// A request is taken while the controller idles; when it is granted, the
// emit state loads the grant into the output register. A release frees both
// resources and the scan pointer visits one seat per cycle over the active
// seats; grants found are emitted. One item is in work at a time; s_tready is
// high only while the controller idles, and the output register lets the next
// item enter while the last grant waits. A stalled m_tready holds the grant
// and pauses emission. Reset frees every resource and clears all waiting seats.
module pairwise_fork_arbiter_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,   // [3:0] seat_count

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [2:0] seat, [7:3] zero
    input  logic [0:0] s_tuser,     // [0] action (0 request, 1 release)

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [2:0] granted_seat, [7:3] zero
    output logic       m_tlast      // last_grant
);

    pfa_pkg::pfa_cmd_t             cmd;
    pfa_pkg::pfa_status_t          status;
    logic [pfa_pkg::SEAT_W-1:0]    grant_seat;

    // Sequence intake, scan and emission
    pfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the stores and the output register
    pfa_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_action (s_tuser[0]),
        .item_seat   (s_tdata[pfa_pkg::SEAT_W-1:0]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_seat    (grant_seat),
        .out_last    (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

    // Pad the granted seat up to a whole byte
    assign m_tdata = {{(8-pfa_pkg::SEAT_W){1'b0}}, grant_seat};

endmodule

[hw/rtl/pfa_checker.sv]
// Port-level checker for the pairwise fork arbiter, bound to the top level.
module pfa_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled grant stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("grant dropped while stalled");

    // A stalled grant keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("grant payload changed while stalled");

    // Seat zero is always active, so its release always starts a scan
    a_release_scans: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == pfa_pkg::ACT_RELEASE
            && s_tdata[pfa_pkg::SEAT_W-1:0] == '0 |=> !s_tready)
        else $error("release did not start a scan");

    // No new item while a run of grants is still open
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during an open grant run");

endmodule

bind pairwise_fork_arbiter_core pfa_checker u_pfa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[dv/tb.sv]
// Self-checking testbench for the pairwise fork arbiter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One request or release as it travels on the slave stream.
    typedef struct packed {
        logic                       action;
        logic [pfa_pkg::SEAT_W-1:0] seat;
    } fork_op_t;

    // One grant as it should appear on the master stream.
    typedef struct packed {
        logic [7:0] tdata;
        logic       tlast;
    } grant_t;

    // longest release plus margin
    localparam int unsigned SETTLE_CYCLES = 2 * pfa_pkg::MAX_SEATS + 8;
    localparam int unsigned LONG_HOLD     = 300;                // receiver hold-off length

    // Block ports; every input has a known value from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;   // [2:0] seat, [7:3] zero
    logic [0:0] s_tuser   = 1'b0;   // [0] action
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [2:0] granted_seat, [7:3] zero
    logic       m_tlast;            // last_grant

    // Arbiter state as the testbench predicts it.
    logic [3:0]                    ring_cfg    = pfa_pkg::COUNT_RESET[3:0];
    logic [pfa_pkg::MAX_SEATS-1:0] fork_free   = '1;
    logic [pfa_pkg::MAX_SEATS-1:0] seat_hungry = '0;
    grant_t                        grants_due[$];

    // Stimulus bookkeeping.
    fork_op_t                      ops_pending[$];
    fork_op_t                      cur_op;
    int unsigned                   ops_queued    = 0;
    int unsigned                   ops_taken     = 0;
    int unsigned                   grants_seen   = 0;
    int unsigned                   grant_errors  = 0;
    int unsigned                   settings_seen = 1;
    int unsigned                   tx_gap;
    int unsigned                   rx_wait;
    int unsigned                   hold_left;
    int unsigned                   hold_tickets  = 0;
    int unsigned                   hold_seen;
    bit                            tx_burst      = 1'b0;
    bit                            rx_steady     = 1'b0;
    logic [pfa_pkg::MAX_SEATS-1:0] seat_claimed  = '0;

    pairwise_fork_arbiter_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    // Clamp the seat-count register to the ring size actually in use.
    function automatic int unsigned ring_len(input logic [3:0] cfg);
        if (cfg == 4'd0)
            return 1;
        if (cfg > pfa_pkg::MAX_SEATS)
            return pfa_pkg::MAX_SEATS;
        return 32'(cfg);
    endfunction

    // Apply one accepted transfer to the predicted forks and queue the grants it causes.
    function automatic void arbitrate_op(input fork_op_t op);
        int unsigned n;
        int unsigned s;
        int unsigned r;
        int unsigned rj;
        int unsigned hits[$];
        grant_t      g;
        n = ring_len(ring_cfg);
        s = op.seat;
        // Seats beyond the ring are dropped without a trace.
        if (s >= n)
            return;
        r = (s + 1 >= n) ? 0 : s + 1;
        if (op.action == pfa_pkg::ACT_REQUEST)
        begin
            if (fork_free[s] && fork_free[r])
            begin
                fork_free[s] = 1'b0;
                fork_free[r] = 1'b0;
                g.tdata = 8'(s);
                g.tlast = 1'b1;
                grants_due.push_back(g);
            end
            else
            begin
                // Blocked: park the seat; a repeat request changes nothing.
                seat_hungry[s] = 1'b1;
            end
        end
        else
        begin
            // Free both forks even if the seat held nothing, then scan upward.
            fork_free[s] = 1'b1;
            fork_free[r] = 1'b1;
            for (int unsigned j = 0; j < n; j++)
            begin
                rj = (j + 1 >= n) ? 0 : j + 1;
                if (seat_hungry[j] && fork_free[j] && fork_free[rj])
                begin
                    fork_free[j]   = 1'b0;
                    fork_free[rj]  = 1'b0;
                    seat_hungry[j] = 1'b0;
                    hits.push_back(j);
                end
            end
            foreach (hits[i])
            begin
                g.tdata = 8'(hits[i]);
                g.tlast = (i == hits.size() - 1);
                grants_due.push_back(g);
            end
        end
    endfunction

    function automatic int unsigned draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // Slave-side driver: hold an offered item until its transfer, then idle
    // for the gap drawn with it, then offer the next pending item.
    always @(posedge clk or negedge rst_n)
    begin : op_driver
        fork_op_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tuser  <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            // Predict before counting so a drained count implies a complete prediction.
            if (s_tvalid && s_tready)
            begin
                arbitrate_op(cur_op);
                ops_taken++;
            end
            if (s_tvalid && !s_tready)
            begin
                // Hold the current item; the block is busy.
            end
            else if (tx_gap > 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (ops_pending.size() > 0)
            begin
                nxt = ops_pending.pop_front();
                cur_op   <= nxt;
                s_tdata  <= {{(8 - pfa_pkg::SEAT_W){1'b0}}, nxt.seat};
                s_tuser  <= nxt.action;
                s_tvalid <= 1'b1;
                tx_gap   <= draw_gap(tx_burst);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Master-side monitor: check each grant transfer against the oldest
    // prediction and pace m_tready with per-grant stalls and long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin : grant_monitor
        grant_t      want;
        int unsigned next_wait;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else
        begin
            next_wait = rx_wait;
            if (m_tvalid && m_tready)
            begin
                grants_seen++;
                if (grants_due.size() == 0)
                begin
                    grant_errors++;
                    $display("%0t: unexpected grant: expected none, actual seat %0d last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (m_tdata !== want.tdata || m_tlast !== want.tlast)
                    begin
                        grant_errors++;
                        $display("%0t: grant mismatch: expected tdata %h last %0b,",
                                 $time, want.tdata, want.tlast,
                                 " actual tdata %h last %0b", m_tdata, m_tlast);
                    end
                end
                next_wait = draw_gap(rx_steady);
            end
            if (hold_seen != hold_tickets)
            begin
                // Start a long hold-off so the block backs up into its input.
                hold_seen <= hold_seen + 1;
                hold_left <= LONG_HOLD;
                rx_wait   <= next_wait;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rx_wait   <= next_wait;
                m_tready  <= 1'b0;
            end
            else if (next_wait > 0)
            begin
                rx_wait  <= next_wait - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_wait  <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_op(input logic action, input int unsigned seat);
        fork_op_t op;
        op.action = action;
        op.seat   = pfa_pkg::SEAT_W'(seat);
        ops_pending.push_back(op);
        ops_queued++;
    endtask

    // Wait for every queued item to transfer and every grant to arrive, then
    // let the longest release scan finish before anything else happens.
    task automatic drain_block();
        do
            @(negedge clk);
        while (ops_taken != ops_queued || grants_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_ring(input logic [3:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ring_cfg   = val;
        settings_seen++;
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: each seat alternates request and release,
    // with some random actions and some seats outside the ring mixed in.
    task automatic random_ops(input int unsigned cnt);
        int unsigned n;
        int unsigned s;
        logic        act;
        n = ring_len(ring_cfg);
        for (int unsigned k = 0; k < cnt; k++)
        begin
            if ($urandom_range(0, 7) != 0)
                s = $urandom_range(0, n - 1);
            else
                s = $urandom_range(0, pfa_pkg::MAX_SEATS - 1);
            if ($urandom_range(0, 4) == 0)
                act = 1'($urandom_range(0, 1));
            else
                act = seat_claimed[s] ? pfa_pkg::ACT_RELEASE : pfa_pkg::ACT_REQUEST;
            seat_claimed[s] = (act == pfa_pkg::ACT_REQUEST);
            push_op(act, s);
        end
    endtask

    initial
    begin : stimulus
        logic [3:0] ring_plan[10];
        ring_plan = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd4};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset ring of five: immediate grant, blocked and repeated requests,
        // seats outside the ring, release of a seat that holds nothing.
        push_op(pfa_pkg::ACT_REQUEST, 0);
        push_op(pfa_pkg::ACT_REQUEST, 1);
        push_op(pfa_pkg::ACT_REQUEST, 1);
        push_op(pfa_pkg::ACT_REQUEST, 4);
        push_op(pfa_pkg::ACT_REQUEST, 2);
        push_op(pfa_pkg::ACT_REQUEST, 7);
        push_op(pfa_pkg::ACT_RELEASE, 7);
        push_op(pfa_pkg::ACT_RELEASE, 0);
        push_op(pfa_pkg::ACT_RELEASE, 2);
        push_op(pfa_pkg::ACT_RELEASE, 3);
        push_op(pfa_pkg::ACT_RELEASE, 1);
        push_op(pfa_pkg::ACT_RELEASE, 4);
        drain_block();

        // Full ring: even seats take every fork, odd seats queue up, then
        // releases hand the forks over through the scan.
        write_ring(4'd8);
        for (int unsigned i = 0; i < 8; i++)
            push_op(pfa_pkg::ACT_REQUEST, (2 * i) % 8 + i / 4);
        for (int unsigned i = 0; i < 4; i++)
            push_op(pfa_pkg::ACT_RELEASE, 2 * i);
        drain_block();

        // Random phases over several ring sizes, extremes included.
        foreach (ring_plan[p])
        begin
            write_ring(ring_plan[p]);
            tx_burst  = (p % 3 == 1) || (p == 0);
            rx_steady = (p % 3 == 1);
            if (p == 0)
                hold_tickets++;  // stall the receiver while the sender keeps pushing
            random_ops(28);
            drain_block();
        end

        $display("covered %0d input transfers and %0d checked grants over %0d seat-count settings",
                 ops_taken, grants_seen, settings_seen);
        $display("included a %0d-cycle receiver hold-off and full drains between phases",
                 LONG_HOLD);
        if (grant_errors == 0 && grants_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Abort a hung run well past the slowest legal run time.
    initial
    begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
